/* sv/rtmp_chunk_header_parser_assert.svh */
// Assertion macros for the RTMP chunk header parser.
// Depends on a clk and rst in the scope of use.
`ifndef RTMP_CHUNK_HEADER_PARSER_ASSERT_SVH
`define RTMP_CHUNK_HEADER_PARSER_ASSERT_SVH

// same-cycle implication
`define RCP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/rcp_pkg.sv */
// Types, constants and helpers shared by the RTMP chunk header parser.
// No dependencies.
`default_nettype none
package rcp_pkg;
  localparam int CHUNK_STREAMS = 128;
  localparam int IDX_W = $clog2(CHUNK_STREAMS);
  localparam logic [23:0] TIME_MARK = 24'hFFFFFF;
  localparam logic [23:0] CHUNK_SIZE_RESET = 24'd128;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int OUT_DEPTH = 4;
  localparam int OPTR_W = $clog2(OUT_DEPTH);

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] FMT_FULL = 2'd0;
  localparam logic [1:0] FMT_SAME_STREAM = 2'd1;
  localparam logic [1:0] FMT_TIME_ONLY = 2'd2;
  localparam logic [1:0] FMT_NONE = 2'd3;

  typedef struct packed {
    logic [7:0]  header_byte;
    logic [23:0] received_so_far;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  header_format;
    logic [16:0] chunk_stream;
    logic [31:0] timestamp;
    logic [31:0] time_delta;
    logic [23:0] message_length;
    logic [7:0]  message_kind;
    logic [31:0] message_stream;
    logic [4:0]  header_length;
    logic [23:0] chunk_payload_length;
  } out_t;

  // parsed header handed from front to back
  typedef struct packed {
    logic [1:0]  fmt;
    logic [16:0] cs;
    logic [31:0] tval;
    logic [23:0] len;
    logic [7:0]  kind;
    logic [31:0] ms;
    logic [4:0]  hlen;
    logic [23:0] so_far;
  } hdr_t;

  typedef struct packed {
    logic [31:0] ts;
    logic [31:0] dl;
    logic [23:0] len;
    logic [7:0]  kind;
    logic [31:0] ms;
  } entry_t;

  function automatic logic [4:0] body_bytes(input logic [1:0] fmt);
    logic [4:0] n;
    case (fmt)
      FMT_FULL:        n = 5'd11;
      FMT_SAME_STREAM: n = 5'd7;
      FMT_TIME_ONLY:   n = 5'd3;
      default:         n = 5'd0;
    endcase
    return n;
  endfunction
endpackage
`default_nettype wire

/* sv/rcp_front.sv */
// Byte-serial chunk header parser: accumulates fields, emits one record per header.
// Depends on rcp_pkg.
`default_nettype none
module rcp_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire rcp_pkg::in_t  item,
  output logic               rec_valid,
  output rcp_pkg::hdr_t      rec
);
  logic [4:0]  pos, pos_next;
  logic [1:0]  fmt, fmt_next;
  logic [1:0]  bb, bb_next;
  logic [16:0] sid, sid_next;
  logic [31:0] tacc, tacc_next;
  logic [23:0] lacc, lacc_next;
  logic [7:0]  kacc, kacc_next;
  logic [31:0] macc, macc_next;
  logic        ext, ext_next;
  logic        done;

  always_comb begin
    logic [7:0] b;
    logic [5:0] low;
    logic [4:0] k;
    logic [5:0] k1;
    logic [5:0] blen;
    b = item.header_byte;
    low = b[5:0];
    k = pos - {3'b0, bb};
    k1 = {1'b0, k} + 6'd1;
    blen = {1'b0, rcp_pkg::body_bytes(fmt)};
    pos_next = pos;
    fmt_next = fmt;
    bb_next = bb;
    sid_next = sid;
    tacc_next = tacc;
    lacc_next = lacc;
    kacc_next = kacc;
    macc_next = macc;
    ext_next = ext;
    done = 1'b0;
    if (pos == 5'd0) begin
      fmt_next = b[7:6];
      tacc_next = '0;
      lacc_next = '0;
      kacc_next = '0;
      macc_next = '0;
      ext_next = 1'b0;
      sid_next = {11'b0, low};
      bb_next = (low >= 6'd2) ? 2'd1 : ((low == 6'd0) ? 2'd2 : 2'd3);
      pos_next = 5'd1;
      done = (bb_next == 2'd1) && (b[7:6] == rcp_pkg::FMT_NONE);
    end else if (pos < {3'b0, bb}) begin
      if (pos == 5'd1) begin
        sid_next = 17'd64 + {9'b0, b};
      end else begin
        sid_next = sid + {1'b0, b, 8'b0};
      end
      pos_next = pos + 5'd1;
      done = (pos_next == {3'b0, bb}) && (fmt == rcp_pkg::FMT_NONE);
    end else begin
      pos_next = pos + 5'd1;
      if (ext) begin
        tacc_next = {tacc[23:0], b};
        done = k1 >= blen + 6'd4;
      end else begin
        if (k < 5'd3) begin
          tacc_next = {8'b0, tacc[15:0], b};
        end else if (k < 5'd6) begin
          lacc_next = {lacc[15:0], b};
        end else if (k == 5'd6) begin
          kacc_next = b;
        end else begin
          case (k)
            5'd7:    macc_next[7:0] = b;
            5'd8:    macc_next[15:8] = b;
            5'd9:    macc_next[23:16] = b;
            5'd10:   macc_next[31:24] = b;
            default: macc_next = macc;
          endcase
        end
        if (k1 >= blen) begin
          if (tacc_next[23:0] == rcp_pkg::TIME_MARK) begin
            ext_next = 1'b1;
            tacc_next = '0;
          end else begin
            done = 1'b1;
          end
        end
      end
    end
    if (done) begin
      rec.hlen = pos_next;
      pos_next = 5'd0;
      ext_next = 1'b0;
    end else begin
      rec.hlen = pos_next;
    end
    rec.fmt = fmt_next;
    rec.cs = sid_next;
    rec.tval = tacc_next;
    rec.len = lacc_next;
    rec.kind = kacc_next;
    rec.ms = macc_next;
    rec.so_far = item.received_so_far;
  end

  assign rec_valid = in_valid && done;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      fmt <= '0;
      bb <= '0;
      sid <= '0;
      tacc <= '0;
      lacc <= '0;
      kacc <= '0;
      macc <= '0;
      ext <= 1'b0;
    end else if (in_valid) begin
      pos <= pos_next;
      fmt <= fmt_next;
      bb <= bb_next;
      sid <= sid_next;
      tacc <= tacc_next;
      lacc <= lacc_next;
      kacc <= kacc_next;
      macc <= macc_next;
      ext <= ext_next;
    end
  end
endmodule
`default_nettype wire

/* sv/rcp_queue.sv */
// Short queue of parsed header records between front and back.
// Depends on rcp_pkg.
`default_nettype none
module rcp_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire rcp_pkg::hdr_t din,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output rcp_pkg::hdr_t      dout
);
  rcp_pkg::hdr_t slots [rcp_pkg::QUEUE_DEPTH];
  logic [rcp_pkg::QPTR_W-1:0] wp, rp;
  logic [rcp_pkg::QPTR_W:0]   cnt;

  assign full = cnt == (rcp_pkg::QPTR_W+1)'(rcp_pkg::QUEUE_DEPTH);
  assign empty = cnt == '0;
  assign dout = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

/* sv/rcp_back.sv */
// Back end: per-stream table lookup, field merge, payload length, result queue.
// Depends on rcp_pkg.
`default_nettype none
module rcp_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [23:0]   rx_size,
  input  wire logic          q_empty,
  input  wire rcp_pkg::hdr_t q_dout,
  output logic               q_pop,
  input  wire logic          pop,
  output logic               empty,
  output rcp_pkg::out_t      result
);
  localparam int IW = rcp_pkg::IDX_W;

  rcp_pkg::entry_t mem [rcp_pkg::CHUNK_STREAMS];
  logic [rcp_pkg::CHUNK_STREAMS-1:0] vbits;

  logic            bv;
  rcp_pkg::hdr_t   brec;
  rcp_pkg::entry_t mem_rd, fwd_data;
  logic            fwd;

  logic            cv;
  rcp_pkg::out_t   cres;
  logic [23:0]     crem;

  rcp_pkg::out_t             ofifo [rcp_pkg::OUT_DEPTH];
  logic [rcp_pkg::OPTR_W-1:0] owp, orp;
  logic [rcp_pkg::OPTR_W:0]   ocount;
  logic                       out_pop;

  logic            in_table, hit, b_wr;
  logic [IW-1:0]   bidx, hidx;
  rcp_pkg::entry_t prev, wdata;
  logic [1:0]      st;
  logic [23:0]     rem, pay;

  assign q_pop = !q_empty &&
      ((ocount + (rcp_pkg::OPTR_W+1)'(bv) + (rcp_pkg::OPTR_W+1)'(cv))
       < (rcp_pkg::OPTR_W+1)'(rcp_pkg::OUT_DEPTH));
  assign hidx = q_dout.cs[IW-1:0];
  assign bidx = brec.cs[IW-1:0];

  always_comb begin
    in_table = brec.cs < 17'(rcp_pkg::CHUNK_STREAMS);
    hit = in_table && vbits[bidx];
    prev = hit ? (fwd ? fwd_data : mem_rd) : '0;
    if (!in_table) begin
      st = rcp_pkg::ST_RANGE;
    end else if (!hit && brec.fmt != rcp_pkg::FMT_FULL) begin
      st = rcp_pkg::ST_MISSING;
    end else begin
      st = rcp_pkg::ST_OK;
    end
    wdata.ms = prev.ms;
    case (brec.fmt)
      rcp_pkg::FMT_FULL: begin
        wdata.dl = '0;
        wdata.len = brec.len;
        wdata.kind = brec.kind;
        wdata.ms = brec.ms;
      end
      rcp_pkg::FMT_SAME_STREAM: begin
        wdata.dl = brec.tval;
        wdata.len = brec.len;
        wdata.kind = brec.kind;
      end
      rcp_pkg::FMT_TIME_ONLY: begin
        wdata.dl = brec.tval;
        wdata.len = prev.len;
        wdata.kind = prev.kind;
      end
      default: begin
        wdata.dl = prev.dl;
        wdata.len = prev.len;
        wdata.kind = prev.kind;
      end
    endcase
    if (brec.fmt == rcp_pkg::FMT_FULL) begin
      wdata.ts = brec.tval;
    end else if (brec.so_far == 24'd0) begin
      wdata.ts = prev.ts + wdata.dl;
    end else begin
      wdata.ts = prev.ts;
    end
    rem = (wdata.len > brec.so_far) ? wdata.len - brec.so_far : 24'd0;
    b_wr = bv && st == rcp_pkg::ST_OK;
    pay = (crem < rx_size) ? crem : rx_size;
  end

  always_ff @(posedge clk) begin
    if (b_wr) begin
      mem[bidx] <= wdata;
    end
    if (q_pop) begin
      mem_rd <= mem[hidx];
      fwd <= b_wr && bidx == hidx;
      fwd_data <= wdata;
      brec <= q_dout;
    end
    if (bv) begin
      cres.status <= st;
      cres.header_format <= brec.fmt;
      cres.chunk_stream <= brec.cs;
      cres.timestamp <= wdata.ts;
      cres.time_delta <= wdata.dl;
      cres.message_length <= wdata.len;
      cres.message_kind <= wdata.kind;
      cres.message_stream <= wdata.ms;
      cres.header_length <= brec.hlen;
      cres.chunk_payload_length <= '0;
      crem <= rem;
    end
    if (cv) begin
      ofifo[owp] <= '{status: cres.status, header_format: cres.header_format,
                      chunk_stream: cres.chunk_stream, timestamp: cres.timestamp,
                      time_delta: cres.time_delta, message_length: cres.message_length,
                      message_kind: cres.message_kind,
                      message_stream: cres.message_stream,
                      header_length: cres.header_length, chunk_payload_length: pay};
    end
  end

  assign empty = ocount == '0;
  assign result = ofifo[orp];
  assign out_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
      bv <= 1'b0;
      cv <= 1'b0;
      owp <= '0;
      orp <= '0;
      ocount <= '0;
    end else begin
      if (b_wr) begin
        vbits[bidx] <= 1'b1;
      end
      bv <= q_pop;
      cv <= bv;
      if (cv) begin
        owp <= owp + 1'b1;
      end
      if (out_pop) begin
        orp <= orp + 1'b1;
      end
      if (cv && !out_pop) begin
        ocount <= ocount + 1'b1;
      end else if (out_pop && !cv) begin
        ocount <= ocount - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

/* sv/rtmp_chunk_header_parser.sv */
// RTMP chunk header parser: one header byte per cycle unless full, one result per header.
// Results pass the record queue, lookup and result registers and output queue. Throughput:
// back end takes one header per cycle (one table read port) while output queue has room.
// Reset: synchronous, clears parser, queues and all stream-table valid bits at once; no
// clearing pass, input is ready the cycle after reset. Chunk size resets to 128.
`include "rtmp_chunk_header_parser_assert.svh"
`default_nettype none
module rtmp_chunk_header_parser (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  output logic              full,
  input  wire rcp_pkg::in_t item,
  output logic              empty,
  input  wire logic         pop,
  output rcp_pkg::out_t     result,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [23:0]  cfg_data
);
  logic          rx_size_we;
  logic [23:0]   rx_size;
  logic          f_push, q_full, q_empty, q_pop;
  rcp_pkg::hdr_t f_rec, q_dout;

  assign cfg_ready = 1'b1;
  assign rx_size_we = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_size <= rcp_pkg::CHUNK_SIZE_RESET;
    end else if (rx_size_we) begin
      rx_size <= cfg_data;
    end
  end

  assign full = q_full;

  rcp_front u_front (
    .clk(clk), .rst(rst), .in_valid(push && !full), .item(item),
    .rec_valid(f_push), .rec(f_rec)
  );

  rcp_queue u_queue (
    .clk(clk), .rst(rst), .push(f_push), .din(f_rec), .full(q_full),
    .pop(q_pop), .empty(q_empty), .dout(q_dout)
  );

  rcp_back u_back (
    .clk(clk), .rst(rst), .rx_size(rx_size), .q_empty(q_empty),
    .q_dout(q_dout), .q_pop(q_pop), .pop(pop), .empty(empty), .result(result)
  );

  `RCP_ASSERT_NOW(a_issue_nonempty, q_pop, !q_empty, "issue from empty queue")
  `RCP_ASSERT_NOW(a_push_not_full, f_push, !q_full, "record push into full queue")
  `RCP_ASSERT_NEXT(a_queue_hold, q_empty && !f_push, q_empty, "record from nothing")
endmodule
`default_nettype wire
